[src/plwd_pkg.sv]
// Package for the pulse-width light decoder: field widths, record kinds,
// and the frame and result beat types shared by the front, back and top.
// No dependencies.
package plwd_pkg;

    // Fixed widths of the port fields.
    localparam int AREA_PORT_W = 20;
    localparam int INTENS_W    = 8;
    localparam int BYTE_W      = 8;
    localparam int ACC_W       = 48;
    localparam int CNT_W       = 32;
    localparam int PRE_W       = 16;
    localparam int HELD_W      = 3;

    // Shortest ON run that counts as a preamble.
    localparam int PREAMBLE_MIN = 8;

    // Reset value of the ON threshold register.
    localparam logic [INTENS_W-1:0] THRESHOLD_RESET = 8'd128;

    // Kind of an output record.
    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } plwd_kind_t;

    // One classified frame as it travels from the front to the back.
    typedef struct packed {
        logic                   eos;
        logic                   on;
        logic [AREA_PORT_W-1:0] area;
    } plwd_frame_t;

    // One result record.
    typedef struct packed {
        plwd_kind_t             record_kind;
        logic [BYTE_W-1:0]      data_byte;
        logic [ACC_W-1:0]       area_total;
        logic [CNT_W-1:0]       on_frames;
        logic [AREA_PORT_W-1:0] smallest_area;
        logic [PRE_W-1:0]       preamble_frames;
        logic                   last;
    } plwd_result_t;

endpackage

[src/plwd_fifo.sv]
// Two-entry first-in first-out queue of registered beats.
// Used between the front and back and in front of the result port.
// No package dependencies.
module plwd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             not_empty
);

    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [WIDTH-1:0] head_reg;
    logic [WIDTH-1:0] head_next;
    logic [WIDTH-1:0] tail_reg;
    logic [WIDTH-1:0] tail_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign dout      = head_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Next contents: the head always holds the oldest beat.
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (do_push && do_pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = din;
            end
            else
            begin
                head_next = tail_reg;
                tail_next = din;
            end
        end
        else if (do_pop)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
        else if (do_push)
        begin
            if (count_reg == 2'd0)
            begin
                head_next = din;
            end
            else
            begin
                tail_next = din;
            end
            count_next = count_reg + 2'd1;
        end
    end

    // Occupancy is control state; the payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

[src/plwd_front.sv]
// Front of the decoder: holds the ON threshold, classifies each frame
// and queues it for the back. Depends on plwd_pkg and plwd_fifo.
module plwd_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [plwd_pkg::INTENS_W-1:0]       cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                blob_found,
    input  logic [plwd_pkg::INTENS_W-1:0]       intensity,
    input  logic [plwd_pkg::AREA_PORT_W-1:0]    blob_area,
    input  logic                                end_of_stream,
    output logic                                frame_valid,
    output plwd_pkg::plwd_frame_t               frame,
    input  logic                                frame_pop
);

    logic [plwd_pkg::INTENS_W-1:0] threshold_reg;
    plwd_pkg::plwd_frame_t         classified;
    logic                          queue_full;

    // Threshold register; the user must write it only while the block is idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= plwd_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wen)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // A frame is ON when a blob was found and it is brighter than the threshold.
    always_comb
    begin
        classified.eos  = end_of_stream;
        classified.on   = blob_found && (intensity > threshold_reg);
        classified.area = blob_area;
    end

    assign in_stall = queue_full;

    // Queue that decouples the front from the back.
    plwd_fifo #(
        .WIDTH($bits(plwd_pkg::plwd_frame_t))
    ) u_frame_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .din       (classified),
        .full      (queue_full),
        .pop       (frame_pop),
        .dout      (frame),
        .not_empty (frame_valid)
    );

endmodule

[src/plwd_back.sv]
// Back of the decoder: run lengths, preamble, bit decisions, byte packing,
// area statistics and the end-of-stream summary, with a result queue.
// Depends on plwd_pkg and plwd_fifo.
module plwd_back #(
    parameter int RUN_BITS  = 16,
    parameter int AREA_BITS = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    frame_valid,
    input  plwd_pkg::plwd_frame_t   frame,
    output logic                    frame_pop,
    output logic                    res_valid,
    output plwd_pkg::plwd_result_t  res,
    input  logic                    res_pop
);

    localparam int AW    = (AREA_BITS < plwd_pkg::AREA_PORT_W) ? AREA_BITS
                                                               : plwd_pkg::AREA_PORT_W;
    localparam int CMP_W = RUN_BITS + 6;
    localparam int SUM_W = plwd_pkg::ACC_W + 1;

    // Decoder state.
    logic                          prev_on_reg,  prev_on_next;
    logic [RUN_BITS-1:0]           run_len_reg,  run_len_next;
    logic [RUN_BITS-1:0]           pre_len_reg,  pre_len_next;
    logic                          stopped_reg,  stopped_next;
    logic [plwd_pkg::BYTE_W-1:0]   shifter_reg,  shifter_next;
    logic [plwd_pkg::HELD_W-1:0]   held_reg,     held_next;
    logic [plwd_pkg::ACC_W-1:0]    acc_reg,      acc_next;
    logic [plwd_pkg::CNT_W-1:0]    cnt_reg,      cnt_next;
    logic [AW-1:0]                 min_reg,      min_next;

    logic                          res_full;
    logic                          fire;
    logic [AW-1:0]                 area;
    logic [SUM_W-1:0]              acc_sum;
    logic                          closing;
    logic                          close_pre;
    logic                          close_bit_try;
    logic [CMP_W-1:0]              len40;
    logic [CMP_W-1:0]              pre9;
    logic [CMP_W-1:0]              len8;
    logic [CMP_W-1:0]              pre5;
    logic                          bit_zero;
    logic                          bit_one;
    logic                          bit_made;
    logic [plwd_pkg::BYTE_W-1:0]   shifted;
    logic                          byte_done;
    logic [RUN_BITS-1:0]           pre_after;
    logic                          pre_ovf;
    logic                          push;
    plwd_pkg::plwd_result_t        res_in;

    assign fire = frame_valid && !res_full;
    assign area = frame.area[AW-1:0];

    // Closing the current run: preamble capture or one decoded bit.
    always_comb
    begin
        closing       = (run_len_reg != '0) && prev_on_reg;
        close_pre     = closing && (pre_len_reg == '0);
        close_bit_try = closing && (pre_len_reg != '0) && !stopped_reg;
        len40     = (CMP_W'(run_len_reg) << 5) + (CMP_W'(run_len_reg) << 3);
        pre9      = (CMP_W'(pre_len_reg) << 3) + CMP_W'(pre_len_reg);
        len8      = CMP_W'(run_len_reg) << 3;
        pre5      = (CMP_W'(pre_len_reg) << 2) + CMP_W'(pre_len_reg);
        bit_zero  = len40 < pre9;
        bit_one   = !bit_zero && (len8 < pre5);
        bit_made  = close_bit_try && (bit_zero || bit_one);
        shifted   = {shifter_reg[plwd_pkg::BYTE_W-2:0], bit_one};
        byte_done = bit_made && (held_reg == '1);
        if (close_pre && (run_len_reg >= RUN_BITS'(plwd_pkg::PREAMBLE_MIN)))
        begin
            pre_after = run_len_reg;
        end
        else
        begin
            pre_after = pre_len_reg;
        end
        pre_ovf = pre_after > RUN_BITS'(17'h0FFFF);
    end

    // Saturating area sum over ON frames.
    assign acc_sum = {1'b0, acc_reg} + SUM_W'(area);

    // Next state and result record for the frame at the head of the queue.
    always_comb
    begin
        prev_on_next = prev_on_reg;
        run_len_next = run_len_reg;
        pre_len_next = pre_len_reg;
        stopped_next = stopped_reg;
        shifter_next = shifter_reg;
        held_next    = held_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        min_next     = min_reg;
        frame_pop    = 1'b0;
        push         = 1'b0;

        res_in.record_kind     = plwd_pkg::KIND_BYTE;
        res_in.data_byte       = shifted;
        res_in.area_total      = '0;
        res_in.on_frames       = '0;
        res_in.smallest_area   = '0;
        res_in.preamble_frames = '0;
        res_in.last            = 1'b1;

        if (fire)
        begin
            if (frame.eos && byte_done)
            begin
                // A byte completes at end of stream: send it first; the entry stays
                // queued, so the summary follows later from the same queue entry.
                push           = 1'b1;
                res_in.last    = 1'b0;
                shifter_next   = '0;
                held_next      = '0;
                prev_on_next   = 1'b0;
            end
            else if (frame.eos)
            begin
                // Summary record, then all state returns to reset.
                push                   = 1'b1;
                frame_pop              = 1'b1;
                res_in.record_kind     = plwd_pkg::KIND_SUMMARY;
                res_in.data_byte       = '0;
                res_in.area_total      = acc_reg;
                res_in.on_frames       = cnt_reg;
                res_in.smallest_area   = (cnt_reg == '0) ? '0
                                         : plwd_pkg::AREA_PORT_W'(min_reg);
                res_in.preamble_frames = pre_ovf ? '1 : plwd_pkg::PRE_W'(pre_after);
                prev_on_next = 1'b0;
                run_len_next = '0;
                pre_len_next = '0;
                stopped_next = 1'b0;
                shifter_next = '0;
                held_next    = '0;
                acc_next     = '0;
                cnt_next     = '0;
                min_next     = '1;
            end
            else
            begin
                frame_pop = 1'b1;
                if (frame.on)
                begin
                    acc_next = acc_sum[SUM_W-1] ? '1 : acc_sum[plwd_pkg::ACC_W-1:0];
                    if (cnt_reg != '1)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (area < min_reg)
                    begin
                        min_next = area;
                    end
                end
                if (frame.on != prev_on_reg)
                begin
                    // Run ends: apply its effect and start a new run.
                    pre_len_next = pre_after;
                    if (close_bit_try && !bit_made)
                    begin
                        stopped_next = 1'b1;
                    end
                    if (byte_done)
                    begin
                        push         = 1'b1;
                        shifter_next = '0;
                        held_next    = '0;
                    end
                    else if (bit_made)
                    begin
                        shifter_next = shifted;
                        held_next    = held_reg + 1'b1;
                    end
                    run_len_next = RUN_BITS'(1);
                    prev_on_next = frame.on;
                end
                else if (run_len_reg != '1)
                begin
                    run_len_next = run_len_reg + 1'b1;
                end
            end
        end
    end

    // Control and counting state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_on_reg <= 1'b0;
            run_len_reg <= '0;
            pre_len_reg <= '0;
            stopped_reg <= 1'b0;
            shifter_reg <= '0;
            held_reg    <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            min_reg     <= '1;
        end
        else
        begin
            prev_on_reg <= prev_on_next;
            run_len_reg <= run_len_next;
            pre_len_reg <= pre_len_next;
            stopped_reg <= stopped_next;
            shifter_reg <= shifter_next;
            held_reg    <= held_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            min_reg     <= min_next;
        end
    end

    // Result queue in front of the output port.
    plwd_fifo #(
        .WIDTH($bits(plwd_pkg::plwd_result_t))
    ) u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (res_in),
        .full      (res_full),
        .pop       (res_pop),
        .dout      (res),
        .not_empty (res_valid)
    );

endmodule

[src/pulse_width_light_decoder.sv]
// Top level of the pulse-width light decoder: front classifier, back decoder.
// Depends on plwd_pkg, plwd_front and plwd_back.
//
//   Channel | Handshake           | Beat
//   --------+---------------------+----------------------------------------------
//   cfg     | cfg_wen             | cfg_wdata (ON threshold)
//   in      | in_valid / in_stall | blob_found, intensity, blob_area, end_of_stream
//   out     | out_valid/out_stall | record_kind ... preamble_frames, last
//
// One frame per cycle while in_stall is low; an accepted frame is registered in the frame
// queue, and any result it yields is registered in the result queue before it shows.
// An end-of-stream beat that completes a byte stays at the head of the frame queue while
// the back sends the byte and then the summary, one result per cycle while the result queue has room.
// Two-entry queues sit between front and back and before the result port, so
// input keeps flowing while a result waits; in_stall rises when the first is full.
// Reset sets the threshold to 128 and returns all decoder state to its reset values at once.
module pulse_width_light_decoder #(
    parameter int RUN_BITS  = 16,
    parameter int AREA_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [plwd_pkg::INTENS_W-1:0]     cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              blob_found,
    input  logic [plwd_pkg::INTENS_W-1:0]     intensity,
    input  logic [plwd_pkg::AREA_PORT_W-1:0]  blob_area,
    input  logic                              end_of_stream,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              record_kind,
    output logic [plwd_pkg::BYTE_W-1:0]       data_byte,
    output logic [plwd_pkg::ACC_W-1:0]        area_total,
    output logic [plwd_pkg::CNT_W-1:0]        on_frames,
    output logic [plwd_pkg::AREA_PORT_W-1:0]  smallest_area,
    output logic [plwd_pkg::PRE_W-1:0]        preamble_frames,
    output logic                              last
);

    logic                   frame_valid;
    plwd_pkg::plwd_frame_t  frame;
    logic                   frame_pop;
    plwd_pkg::plwd_result_t res;
    logic                   res_pop;

    // Front: threshold register, classification and frame queue.
    plwd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .blob_found    (blob_found),
        .intensity     (intensity),
        .blob_area     (blob_area),
        .end_of_stream (end_of_stream),
        .frame_valid   (frame_valid),
        .frame         (frame),
        .frame_pop     (frame_pop)
    );

    // Back: run decoding, statistics and result queue.
    plwd_back #(
        .RUN_BITS  (RUN_BITS),
        .AREA_BITS (AREA_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .frame_pop   (frame_pop),
        .res_valid   (out_valid),
        .res         (res),
        .res_pop     (res_pop)
    );

    assign res_pop = out_valid && !out_stall;

    // Result beat fields.
    assign record_kind     = res.record_kind;
    assign data_byte       = res.data_byte;
    assign area_total      = res.area_total;
    assign on_frames       = res.on_frames;
    assign smallest_area   = res.smallest_area;
    assign preamble_frames = res.preamble_frames;
    assign last            = res.last;

endmodule

[test/plwd_checker.sv]
// Checker for the pulse-width light decoder: watches the configuration, frame and
// result channels, predicts every result beat and compares it field by field.
// Depends on plwd_pkg for field widths, the record kinds and the result beat type.
module plwd_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [plwd_pkg::INTENS_W-1:0]    cfg_wdata,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             blob_found,
    input  logic [plwd_pkg::INTENS_W-1:0]    intensity,
    input  logic [plwd_pkg::AREA_PORT_W-1:0] blob_area,
    input  logic                             end_of_stream,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic                             record_kind,
    input  logic [plwd_pkg::BYTE_W-1:0]      data_byte,
    input  logic [plwd_pkg::ACC_W-1:0]       area_total,
    input  logic [plwd_pkg::CNT_W-1:0]       on_frames,
    input  logic [plwd_pkg::AREA_PORT_W-1:0] smallest_area,
    input  logic [plwd_pkg::PRE_W-1:0]       preamble_frames,
    input  logic                             last,
    output int                               fail_count,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [plwd_pkg::ACC_W-1:0] ACC_FULL = '1;
    localparam logic [plwd_pkg::CNT_W-1:0] CNT_FULL = '1;
    localparam logic [plwd_pkg::PRE_W-1:0] RUN_FULL = '1;

    // Decoder state as the block should hold it.
    logic [plwd_pkg::INTENS_W-1:0]    threshold;
    logic                             last_on;
    logic [plwd_pkg::PRE_W-1:0]       run_count;
    logic [plwd_pkg::PRE_W-1:0]       preamble_len;
    logic                             halted;
    logic [plwd_pkg::BYTE_W-1:0]      shift_bits;
    logic [plwd_pkg::HELD_W-1:0]      bit_count;
    logic [plwd_pkg::ACC_W-1:0]       area_sum;
    logic [plwd_pkg::CNT_W-1:0]       on_count;
    logic [plwd_pkg::AREA_PORT_W-1:0] area_low;

    // Result beats predicted but not yet seen, oldest first.
    plwd_pkg::plwd_result_t expected_records[$];

    function automatic void clear_decoder();
        last_on      = 1'b0;
        run_count    = '0;
        preamble_len = '0;
        halted       = 1'b0;
        shift_bits   = '0;
        bit_count    = '0;
        area_sum     = '0;
        on_count     = '0;
        area_low     = '1;
    endfunction

    function automatic void push_record(plwd_pkg::plwd_kind_t kind,
                                        logic [plwd_pkg::BYTE_W-1:0] value,
                                        logic [plwd_pkg::ACC_W-1:0] total,
                                        logic [plwd_pkg::CNT_W-1:0] frames,
                                        logic [plwd_pkg::AREA_PORT_W-1:0] smallest,
                                        logic [plwd_pkg::PRE_W-1:0] pre, logic is_last);
        plwd_pkg::plwd_result_t rec;
        rec.record_kind     = kind;
        rec.data_byte       = value;
        rec.area_total      = total;
        rec.on_frames       = frames;
        rec.smallest_area   = smallest;
        rec.preamble_frames = pre;
        rec.last            = is_last;
        expected_records.insert(expected_records.size(), rec);
    endfunction

    // Ends the current run. An ON run may become the preamble or yield one bit;
    // returns 1 when that bit completes a byte.
    function automatic bit close_pulse(output logic [plwd_pkg::BYTE_W-1:0] done_byte);
        longint unsigned len;
        longint unsigned pre;
        logic pulse_bit;
        done_byte = '0;
        len = run_count;
        pre = preamble_len;
        if (len == 0 || !last_on)
            return 1'b0;
        if (pre == 0) begin
            if (len >= plwd_pkg::PREAMBLE_MIN)
                preamble_len = run_count;
            return 1'b0;
        end
        if (halted)
            return 1'b0;
        if (40 * len < 9 * pre)
            pulse_bit = 1'b0;
        else if (8 * len < 5 * pre)
            pulse_bit = 1'b1;
        else begin
            halted = 1'b1;
            return 1'b0;
        end
        shift_bits = {shift_bits[plwd_pkg::BYTE_W-2:0], pulse_bit};
        if (bit_count == plwd_pkg::HELD_W'(7)) begin
            done_byte  = shift_bits;
            shift_bits = '0;
            bit_count  = '0;
            return 1'b1;
        end
        bit_count = bit_count + 1'b1;
        return 1'b0;
    endfunction

    // Advances the decoder by one accepted frame beat and queues what it emits.
    function automatic void decode_frame(logic found, logic [plwd_pkg::INTENS_W-1:0] inten,
                                         logic [plwd_pkg::AREA_PORT_W-1:0] area, logic eos);
        logic [plwd_pkg::BYTE_W-1:0] done_byte;
        logic on;
        if (eos) begin
            if (close_pulse(done_byte))
                push_record(plwd_pkg::KIND_BYTE, done_byte, '0, '0, '0, '0, 1'b0);
            push_record(plwd_pkg::KIND_SUMMARY, '0, area_sum, on_count,
                        (on_count == 0) ? '0 : area_low, preamble_len, 1'b1);
            clear_decoder();
            return;
        end
        on = found && (inten > threshold);
        if (on) begin
            if (ACC_FULL - area_sum < plwd_pkg::ACC_W'(area))
                area_sum = ACC_FULL;
            else
                area_sum = area_sum + plwd_pkg::ACC_W'(area);
            if (on_count != CNT_FULL)
                on_count = on_count + 1'b1;
            if (area < area_low)
                area_low = area;
        end
        if (on != last_on) begin
            if (close_pulse(done_byte))
                push_record(plwd_pkg::KIND_BYTE, done_byte, '0, '0, '0, '0, 1'b1);
            run_count = '0;
            last_on   = on;
        end
        if (run_count != RUN_FULL)
            run_count = run_count + 1'b1;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare result beats first, then take in configuration writes and frame beats.
    always @(posedge clk or negedge rst_n) begin
        plwd_pkg::plwd_result_t want;
        if (!rst_n) begin
            threshold = plwd_pkg::THRESHOLD_RESET;
            clear_decoder();
            expected_records.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_records.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("record_kind", want.record_kind, record_kind);
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("area_total", want.area_total, area_total);
                    check_field("on_frames", want.on_frames, on_frames);
                    check_field("smallest_area", want.smallest_area, smallest_area);
                    check_field("preamble_frames", want.preamble_frames, preamble_frames);
                    check_field("last", want.last, last);
                end
            end
            if (cfg_wen)
                threshold = cfg_wdata;
            if (in_valid && !in_stall)
                decode_frame(blob_found, intensity, blob_area, end_of_stream);
            pending = expected_records.size();
        end
    end

endmodule

[test/pulse_width_light_decoder_test.sv]
// Testbench top for the pulse-width light decoder: drives frame beats, threshold
// writes and result back-pressure, and gives the verdict.
// Depends on plwd_pkg, the decoder RTL and plwd_checker.
module pulse_width_light_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 200;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_wen;
    logic [plwd_pkg::INTENS_W-1:0]    cfg_wdata;
    logic                             in_valid;
    logic                             in_stall;
    logic                             blob_found;
    logic [plwd_pkg::INTENS_W-1:0]    intensity;
    logic [plwd_pkg::AREA_PORT_W-1:0] blob_area;
    logic                             end_of_stream;
    logic                             out_valid;
    logic                             out_stall;
    logic                             record_kind;
    logic [plwd_pkg::BYTE_W-1:0]      data_byte;
    logic [plwd_pkg::ACC_W-1:0]       area_total;
    logic [plwd_pkg::CNT_W-1:0]       on_frames;
    logic [plwd_pkg::AREA_PORT_W-1:0] smallest_area;
    logic [plwd_pkg::PRE_W-1:0]       preamble_frames;
    logic                             last;

    int fail_count;
    int pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int items_sent = 0;
    int on_level = plwd_pkg::THRESHOLD_RESET;

    pulse_width_light_decoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .blob_found      (blob_found),
        .intensity       (intensity),
        .blob_area       (blob_area),
        .end_of_stream   (end_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .record_kind     (record_kind),
        .data_byte       (data_byte),
        .area_total      (area_total),
        .on_frames       (on_frames),
        .smallest_area   (smallest_area),
        .preamble_frames (preamble_frames),
        .last            (last)
    );

    plwd_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .blob_found      (blob_found),
        .intensity       (intensity),
        .blob_area       (blob_area),
        .end_of_stream   (end_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .record_kind     (record_kind),
        .data_byte       (data_byte),
        .area_total      (area_total),
        .on_frames       (on_frames),
        .smallest_area   (smallest_area),
        .preamble_frames (preamble_frames),
        .last            (last),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, or a long hold-off whenever one is asked for.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_served != holds_asked) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_served++;
            end else begin
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    // Offers one frame beat and returns at the falling edge after it is taken.
    task automatic send_beat(logic found, logic [plwd_pkg::INTENS_W-1:0] inten,
                             logic [plwd_pkg::AREA_PORT_W-1:0] area, logic eos);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        blob_found    <= found;
        intensity     <= inten;
        blob_area     <= area;
        end_of_stream <= eos;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    // Mostly random areas, with the zero and full-scale extremes now and then.
    function automatic logic [plwd_pkg::AREA_PORT_W-1:0] pick_area();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return plwd_pkg::AREA_PORT_W'($urandom);
        endcase
    endfunction

    task automatic send_on(int count);
        repeat (count)
            send_beat(1'b1, plwd_pkg::INTENS_W'($urandom_range(on_level + 1, 255)),
                      pick_area(), 1'b0);
    endtask

    // OFF frames are either no blob at all or a blob too dim to count.
    task automatic send_off(int count);
        repeat (count) begin
            if ($urandom_range(0, 1))
                send_beat(1'b0, plwd_pkg::INTENS_W'($urandom), pick_area(), 1'b0);
            else
                send_beat(1'b1, plwd_pkg::INTENS_W'($urandom_range(0, on_level)),
                          pick_area(), 1'b0);
        end
    endtask

    task automatic send_eos();
        send_beat(1'(($urandom)), plwd_pkg::INTENS_W'($urandom), pick_area(), 1'b1);
    endtask

    // A framed message: preamble, then one ON run per bit with OFF gaps, then end of
    // stream. A broken message puts a run too long for a bit somewhere in it.
    task automatic send_message(bit broken);
        int pre_len;
        int zero_max;
        int one_min;
        int one_max;
        int nbits;
        int stop_at;
        pre_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(8, 16);
        zero_max = (9 * pre_len - 1) / 40;
        one_min  = (9 * pre_len + 39) / 40;
        one_max  = (5 * pre_len - 1) / 8;
        nbits = 8 * $urandom_range(1, 2) + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0);
        stop_at = broken ? $urandom_range(0, nbits - 1) : -1;
        if ($urandom_range(0, 3) == 0)
            send_off($urandom_range(1, 3));
        // A short ON run ahead of the preamble must not be taken for it.
        if ($urandom_range(0, 3) == 0) begin
            send_on($urandom_range(1, plwd_pkg::PREAMBLE_MIN - 1));
            send_off($urandom_range(1, 3));
        end
        send_on(pre_len);
        for (int i = 0; i < nbits; i++) begin
            send_off($urandom_range(1, 4));
            if (i == stop_at)
                send_on($urandom_range(one_max + 1, one_max + 8));
            else if ($urandom_range(0, 1))
                send_on($urandom_range(1, zero_max));
            else
                send_on($urandom_range(one_min, one_max));
        end
        if ($urandom_range(0, 1))
            send_off($urandom_range(1, 3));
        send_eos();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 30))
            send_beat(1'($urandom), plwd_pkg::INTENS_W'($urandom), pick_area(), 1'b0);
        send_eos();
    endtask

    // Waits until every predicted result has come and the pipeline has drained.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_threshold(int value);
        wait_idle();
        cfg_wdata <= plwd_pkg::INTENS_W'(value);
        cfg_wen   <= 1'b1;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        on_level = value;
    endtask

    // One random phase: mostly well-formed messages, some broken ones and noise.
    task automatic run_phase(int tx_pct, int rx_pct, int value, bit with_hold);
        int start_items;
        set_threshold(value);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start_items = items_sent;
        // End-of-stream beats back to back during a hold-off fill the block up.
        if (with_hold) begin
            holds_asked++;
            repeat (10) send_eos();
        end
        while (items_sent - start_items < PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
                7:       send_message(1'b1);
                8:       send_noise();
                9:       send_eos();
                default: send_message(1'b0);
            endcase
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        blob_found    = 1'b0;
        intensity     = '0;
        blob_area     = '0;
        end_of_stream = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: an empty stream, end of stream with the other fields set, the
        // threshold boundary and the area extremes, all at the reset threshold.
        send_beat(1'b0, '0, '0, 1'b1);
        send_beat(1'b1, 8'd255, '1, 1'b1);
        send_beat(1'b1, 8'd128, '1, 1'b0);
        send_beat(1'b1, 8'd129, '0, 1'b0);
        send_beat(1'b1, 8'd255, '1, 1'b0);
        send_beat(1'b0, 8'd255, 20'd5, 1'b0);
        send_beat(1'b1, 8'd0, 20'd9, 1'b0);
        send_beat(1'b1, 8'd200, 20'd1, 1'b0);
        send_beat(1'b0, '0, '0, 1'b1);

        // Highest threshold: nothing can be ON, so the summary totals are all zeros.
        set_threshold(255);
        send_beat(1'b1, 8'd255, '1, 1'b0);
        send_beat(1'b1, 8'd255, 20'd7, 1'b0);
        send_beat(1'b1, 8'd254, 20'd3, 1'b0);
        send_eos();

        run_phase(17, 77, 0, 1'b0);
        run_phase(77, 17, $urandom_range(1, 200), 1'b0);
        run_phase(0, 0, $urandom_range(0, 200), 1'b1);

        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
